FILE: rtl/core/pira_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pira_pkg
// Shared types and constants of the positional insert/remove array.
// ----------------------------------------------------------------------------
package pira_pkg;

  // Default number of words in the store.
  localparam int unsigned PiraDepth = 8;

  // Fixed field widths.
  localparam int unsigned ActW  = 2;
  localparam int unsigned PosW  = 4;
  localparam int unsigned WordW = 32;

  // Action codes; the unused code behaves as a read.
  typedef enum logic [ActW-1:0] {
    ACT_READ   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_SPARE  = 2'd3
  } action_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the command beat
    logic exec;     // apply the shift to the store
    logic respond;  // present the result beat
  } ctrl_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/pira_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pira_ctrl
// Sequencer: accepts a command, triggers the store update, then emits one
// result beat.
// ----------------------------------------------------------------------------
module pira_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output pira_pkg::ctrl_cmd_t cmd_o
);
  import pira_pkg::*;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output decode.
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_RESP: cmd_o.respond = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/pira_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pira_datapath
// Word store with per-element shift lanes, command capture and result select.
// ----------------------------------------------------------------------------
module pira_datapath #(
  parameter int unsigned DEPTH = pira_pkg::PiraDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pira_pkg::ctrl_cmd_t              cmd_i,
  input  logic [pira_pkg::ActW-1:0]        action_i,
  input  logic [pira_pkg::PosW-1:0]        position_i,
  input  logic signed [pira_pkg::WordW-1:0] new_value_i,
  output logic                             done_o,
  output logic                             status_o,
  output logic signed [pira_pkg::WordW-1:0] word_at_position_o
);
  import pira_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [ActW-1:0]  action_q;
  logic [PosW-1:0]  pos_q;
  logic [WordW-1:0] value_q;
  logic [WordW-1:0] store_q [DEPTH];
  logic             pos_valid;
  logic             do_insert;
  logic             do_remove;

  // Capture the accepted command beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      pos_q    <= position_i;
      value_q  <= new_value_i;
    end
  end

  assign pos_valid = (pos_q < PosW'(DEPTH));
  assign do_insert = cmd_i.exec && pos_valid && (action_q == ACT_INSERT);
  assign do_remove = cmd_i.exec && pos_valid && (action_q == ACT_REMOVE);

  // One lane per element; each lane takes its neighbor or the new word.
  for (genvar k = 0; k < DEPTH; k++) begin : g_lane
    logic [WordW-1:0] below;
    logic [WordW-1:0] above;

    if (k > 0) begin : g_below
      assign below = store_q[k-1];
    end else begin : g_no_below
      assign below = '0;
    end

    // The last element is cleared on a remove.
    if (k < DEPTH - 1) begin : g_above
      assign above = store_q[k+1];
    end else begin : g_no_above
      assign above = '0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        store_q[k] <= '0;
      end else if (do_insert) begin
        if (PosW'(k) == pos_q) begin
          store_q[k] <= value_q;
        end else if (PosW'(k) > pos_q) begin
          store_q[k] <= below;
        end
      end else if (do_remove) begin
        if (PosW'(k) >= pos_q) begin
          store_q[k] <= above;
        end
      end
    end
  end

  // Result beat: word now at the position, or invalid status with zero.
  assign done_o             = cmd_i.respond;
  assign status_o           = !pos_valid;
  assign word_at_position_o = pos_valid ? store_q[pos_q[IdxW-1:0]] : '0;

endmodule
`default_nettype wire

FILE: rtl/core/positional_insert_remove_array.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_remove_array
// Sequence: an accepted command passes through the update and result states;
// its result beat is on done_o for exactly one cycle; the receiver cannot
// stall it. A new command is taken only when busy is low, after the result
// beat; the shift of all elements happens at once in the update step.
// Reset: asynchronous active low; the store is cleared to zero at once.
// ----------------------------------------------------------------------------
module positional_insert_remove_array #(
  parameter int unsigned DEPTH = pira_pkg::PiraDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [pira_pkg::ActW-1:0]         action_i,
  input  logic [pira_pkg::PosW-1:0]         position_i,
  input  logic signed [pira_pkg::WordW-1:0] new_value_i,
  output logic                              done_o,
  output logic                              status_o,
  output logic signed [pira_pkg::WordW-1:0] word_at_position_o
);
  import pira_pkg::*;

  ctrl_cmd_t cmd;

  // Sequencer.
  pira_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // Store and result path.
  pira_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .action_i           (action_i),
    .position_i         (position_i),
    .new_value_i        (new_value_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .word_at_position_o (word_at_position_o)
  );

endmodule
`default_nettype wire
